// ----- src/cts_pkg.sv -----
// Shared types and constants for the capacity timeline scheduler.
// Depends on nothing; used by capacity_timeline_scheduler.
package cts_pkg;

   // Default table depth and time width.
   localparam int MAX_INTERVALS_DEF = 64;
   localparam int TIME_BITS_DEF     = 32;

   // Width of a usage count and of the capacity register.
   localparam int UTIL_BITS = 16;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_FIT = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_BOUNDS = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN_I,
      ST_SCAN_K,
      ST_FIT,
      ST_SHIFT,
      ST_SPLIT_HI,
      ST_SPLIT_LO,
      ST_CSCAN,
      ST_CCHECK,
      ST_MERGE,
      ST_DONE
   } state_type;

endpackage

// ----- src/capacity_timeline_scheduler.sv -----
// Capacity timeline scheduler: interval table, sequencer and response register.
// Depends on cts_pkg.
//
// The block keeps a sorted table of contiguous intervals covering [0, infinity) in a
// single-port-read, single-port-write memory of MAX_INTERVALS words; each word holds an
// interval's end tick and usage, and an interval begins where the one below it ends.
// A request is taken only while the sequencer is idle, and its response is registered so
// the next request can be accepted while the response still waits. A schedule request
// walks the table one entry per cycle from each candidate interval in turn;
// a successful schedule then moves the upper part of the table, one entry per cycle, and
// writes up to two split entries. A complete request makes one pass over the table to
// find its bounds and a second pass to subtract the usage and merge idle intervals.
// Every walk reads through the one memory read port. After reset the block writes the
// initial interval in its init state before it accepts requests.
module capacity_timeline_scheduler #(
   parameter int MAX_INTERVALS = cts_pkg::MAX_INTERVALS_DEF,
   parameter int TIME_BITS     = cts_pkg::TIME_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_mode,
   input  logic [cts_pkg::UTIL_BITS-1:0]  req_util,
   input  logic [TIME_BITS-1:0]           req_start_time,
   input  logic [TIME_BITS-1:0]           req_duration,
   input  logic [TIME_BITS-1:0]           req_finish_time,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [TIME_BITS-1:0]           rsp_granted_start,
   output logic [1:0]                     rsp_status,
   input  logic                           csr_we,
   input  logic [cts_pkg::UTIL_BITS-1:0]  csr_wdata
);

   localparam int UB = cts_pkg::UTIL_BITS;
   localparam int IW = $clog2(MAX_INTERVALS);
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int WW = TIME_BITS + UB;
   localparam logic [TIME_BITS-1:0] TIME_INF = {TIME_BITS{1'b1}};
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [CW:0]   MAX_C = (CW + 1)'(MAX_INTERVALS);

   // Interval table memory.
   logic [WW-1:0] mem [MAX_INTERVALS];
   logic [WW-1:0] rd_q_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [WW-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   logic [TIME_BITS-1:0] q_end;
   logic [UB-1:0]        q_use;
   assign q_end = rd_q_ff[WW-1:UB];
   assign q_use = rd_q_ff[UB-1:0];

   // Control and working registers.
   cts_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [UB-1:0]        cap_ff, cap_in;
   logic [UB-1:0]        util_ff, util_in;
   logic [TIME_BITS-1:0] st_ff, st_in;
   logic [TIME_BITS-1:0] dur_ff, dur_in;
   logic [TIME_BITS-1:0] fin_ff, fin_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [CW-1:0]        m_ff, m_in;
   logic [CW-1:0]        a_ff, a_in;
   logic [CW-1:0]        b_ff, b_in;
   logic                 fa_ff, fa_in;
   logic                 fb_ff, fb_in;
   logic [TIME_BITS-1:0] beg_i_ff, beg_i_in;
   logic [TIME_BITS-1:0] end_i_ff, end_i_in;
   logic [UB-1:0]        use_i_ff, use_i_in;
   logic [TIME_BITS-1:0] end_k_ff, end_k_in;
   logic [UB-1:0]        use_k_ff, use_k_in;
   logic [TIME_BITS-1:0] s_ff, s_in;
   logic [TIME_BITS-1:0] f_ff, f_in;
   logic [UB-1:0]        peak_ff, peak_in;
   logic                 a1_ff, a1_in;
   logic                 a2_ff, a2_in;
   logic [TIME_BITS-1:0] prev_end_ff, prev_end_in;
   logic [UB-1:0]        last_use_ff, last_use_in;
   logic [TIME_BITS-1:0] res_grant_ff, res_grant_in;
   cts_pkg::status_type  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0] rsp_grant_ff, rsp_grant_in;
   cts_pkg::status_type  rsp_status_ff, rsp_status_in;

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cts_pkg::ST_INIT;
         n_ff         <= ONE_C;
         cap_ff       <= UB'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers, no reset needed.
   always_ff @(posedge clock) begin
      util_ff       <= util_in;
      st_ff         <= st_in;
      dur_ff        <= dur_in;
      fin_ff        <= fin_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      m_ff          <= m_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      fa_ff         <= fa_in;
      fb_ff         <= fb_in;
      beg_i_ff      <= beg_i_in;
      end_i_ff      <= end_i_in;
      use_i_ff      <= use_i_in;
      end_k_ff      <= end_k_in;
      use_k_ff      <= use_k_in;
      s_ff          <= s_in;
      f_ff          <= f_in;
      peak_ff       <= peak_in;
      a1_ff         <= a1_in;
      a2_ff         <= a2_in;
      prev_end_ff   <= prev_end_in;
      last_use_ff   <= last_use_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Shared helper values.
   logic [TIME_BITS-1:0] cand_s;
   logic [TIME_BITS-1:0] cand_f;
   logic [UB:0]          need;
   logic [CW:0]          grown;
   logic [CW-1:0]        shift_amt;
   logic [UB-1:0]        sub_use;
   logic [CW-1:0]        i_next, k_next, j_next, j_prev;

   assign cand_s    = (st_ff > beg_i_ff) ? st_ff : beg_i_ff;
   assign cand_f    = cand_s + dur_ff;
   assign need      = {1'b0, peak_ff} + {1'b0, util_ff};
   assign grown     = {1'b0, n_ff} + (CW + 1)'(a1_ff) + (CW + 1)'(a2_ff);
   assign shift_amt = CW'(a1_ff) + ((j_ff > k_ff) ? CW'(a2_ff) : '0);
   assign sub_use   = (q_use > util_ff) ? (q_use - util_ff) : '0;
   assign i_next    = i_ff + ONE_C;
   assign k_next    = k_ff + ONE_C;
   assign j_next    = j_ff + ONE_C;
   assign j_prev    = j_ff - ONE_C;

   // Sequencer: next state, memory access and working register updates.
   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      cap_in        = csr_we ? csr_wdata : cap_ff;
      util_in       = util_ff;
      st_in         = st_ff;
      dur_in        = dur_ff;
      fin_in        = fin_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      m_in          = m_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      fa_in         = fa_ff;
      fb_in         = fb_ff;
      beg_i_in      = beg_i_ff;
      end_i_in      = end_i_ff;
      use_i_in      = use_i_ff;
      end_k_in      = end_k_ff;
      use_k_in      = use_k_ff;
      s_in          = s_ff;
      f_in          = f_ff;
      peak_in       = peak_ff;
      a1_in         = a1_ff;
      a2_in         = a2_ff;
      prev_end_in   = prev_end_ff;
      last_use_in   = last_use_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      req_ready     = 1'b0;

      unique case (state_ff)
         // Write the single initial interval after reset.
         cts_pkg::ST_INIT: begin
            wr_en    = 1'b1;
            wr_data  = {TIME_INF, UB'(0)};
            n_in     = ONE_C;
            state_in = cts_pkg::ST_IDLE;
         end

         // Take a request and start the matching walk, or finish at once on an empty or reversed complete.
         cts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               util_in      = req_util;
               st_in        = req_start_time;
               dur_in       = req_duration;
               fin_in       = req_finish_time;
               res_grant_in = '0;
               i_in         = '0;
               j_in         = '0;
               beg_i_in     = '0;
               prev_end_in  = '0;
               fa_in        = 1'b0;
               fb_in        = 1'b0;
               if (!req_mode) begin
                  state_in = cts_pkg::ST_SCAN_I;
               end else if (req_finish_time == req_start_time) begin
                  res_status_in = cts_pkg::STATUS_OK;
                  state_in      = cts_pkg::ST_DONE;
               end else if (req_finish_time < req_start_time) begin
                  res_status_in = cts_pkg::STATUS_BOUNDS;
                  state_in      = cts_pkg::ST_DONE;
               end else begin
                  state_in = cts_pkg::ST_CSCAN;
               end
            end
         end

         // Candidate interval i has arrived from memory.
         cts_pkg::ST_SCAN_I: begin
            if (i_ff == n_ff) begin
               res_status_in = cts_pkg::STATUS_NO_FIT;
               state_in      = cts_pkg::ST_DONE;
            end else if (q_end <= st_ff) begin
               i_in     = i_next;
               beg_i_in = q_end;
               rd_addr  = i_next[IW-1:0];
            end else begin
               // The start sits in this interval; check overflow of the finish.
               if (dur_ff > (TIME_INF - ((st_ff > beg_i_ff) ? st_ff : beg_i_ff))) begin
                  res_status_in = cts_pkg::STATUS_NO_FIT;
                  state_in      = cts_pkg::ST_DONE;
               end else begin
                  s_in     = cand_s;
                  f_in     = cand_f;
                  end_i_in = q_end;
                  use_i_in = q_use;
                  peak_in  = q_use;
                  k_in     = i_ff;
                  end_k_in = q_end;
                  use_k_in = q_use;
                  if (cand_f <= q_end) begin
                     state_in = cts_pkg::ST_FIT;
                  end else begin
                     k_in     = i_next;
                     rd_addr  = i_next[IW-1:0];
                     state_in = cts_pkg::ST_SCAN_K;
                  end
               end
            end
         end

         // Walk the window for the peak usage.
         cts_pkg::ST_SCAN_K: begin
            if (k_ff == n_ff) begin
               res_status_in = cts_pkg::STATUS_NO_FIT;
               state_in      = cts_pkg::ST_DONE;
            end else begin
               peak_in  = (q_use > peak_ff) ? q_use : peak_ff;
               end_k_in = q_end;
               use_k_in = q_use;
               if (f_ff <= q_end) begin
                  state_in = cts_pkg::ST_FIT;
               end else begin
                  k_in    = k_next;
                  rd_addr = k_next[IW-1:0];
               end
            end
         end

         // Capacity check, then either commit or try the next interval.
         cts_pkg::ST_FIT: begin
            if (need <= {1'b0, cap_ff}) begin
               if (dur_ff == '0) begin
                  res_grant_in  = s_ff;
                  res_status_in = cts_pkg::STATUS_OK;
                  state_in      = cts_pkg::ST_DONE;
               end else begin
                  a1_in = (s_ff > beg_i_ff);
                  a2_in = (f_ff < end_k_ff);
                  if (({1'b0, n_ff} + (CW + 1)'(s_ff > beg_i_ff)
                       + (CW + 1)'(f_ff < end_k_ff)) > MAX_C) begin
                     res_status_in = cts_pkg::STATUS_FULL;
                     state_in      = cts_pkg::ST_DONE;
                  end else begin
                     j_in     = n_ff - ONE_C;
                     rd_addr  = IW'(n_ff - ONE_C);
                     state_in = cts_pkg::ST_SHIFT;
                  end
               end
            end else begin
               i_in     = i_next;
               beg_i_in = end_i_ff;
               rd_addr  = i_next[IW-1:0];
               state_in = cts_pkg::ST_SCAN_I;
            end
         end

         // Move entries up from the top, adding the usage inside the window.
         cts_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = IW'(j_ff + shift_amt);
            if (j_ff > k_ff) begin
               wr_data = rd_q_ff;
            end else if (j_ff == k_ff) begin
               wr_data = {f_ff, UB'(q_use + util_ff)};
            end else begin
               wr_data = {q_end, UB'(q_use + util_ff)};
            end
            if (j_ff == i_ff) begin
               state_in = cts_pkg::ST_SPLIT_HI;
            end else begin
               j_in    = j_prev;
               rd_addr = j_prev[IW-1:0];
            end
         end

         // Remainder of the last interval past the finish.
         cts_pkg::ST_SPLIT_HI: begin
            wr_en    = a2_ff;
            wr_addr  = IW'(k_ff + CW'(a1_ff) + ONE_C);
            wr_data  = {end_k_ff, use_k_ff};
            state_in = cts_pkg::ST_SPLIT_LO;
         end

         // Part of the first interval before the start.
         cts_pkg::ST_SPLIT_LO: begin
            wr_en         = a1_ff;
            wr_addr       = i_ff[IW-1:0];
            wr_data       = {s_ff, use_i_ff};
            n_in          = grown[CW-1:0];
            res_grant_in  = s_ff;
            res_status_in = cts_pkg::STATUS_OK;
            state_in      = cts_pkg::ST_DONE;
         end

         // Find the intervals bounding a completed task.
         cts_pkg::ST_CSCAN: begin
            if (j_ff == n_ff) begin
               state_in = cts_pkg::ST_CCHECK;
            end else begin
               if (!fa_ff && prev_end_ff == st_ff) begin
                  fa_in = 1'b1;
                  a_in  = j_ff;
               end
               if (!fb_ff && q_end == fin_ff) begin
                  fb_in = 1'b1;
                  b_in  = j_ff;
               end
               prev_end_in = q_end;
               j_in        = j_next;
               rd_addr     = j_next[IW-1:0];
            end
         end

         cts_pkg::ST_CCHECK: begin
            if (!fa_ff || !fb_ff || (b_ff < a_ff)) begin
               res_status_in = cts_pkg::STATUS_BOUNDS;
               state_in      = cts_pkg::ST_DONE;
            end else begin
               j_in     = '0;
               m_in     = '0;
               state_in = cts_pkg::ST_MERGE;
            end
         end

         // Subtract the usage and fold runs of idle intervals in place.
         cts_pkg::ST_MERGE: begin
            if (j_ff == n_ff) begin
               n_in          = m_ff;
               res_status_in = cts_pkg::STATUS_OK;
               state_in      = cts_pkg::ST_DONE;
            end else begin
               wr_en = 1'b1;
               if ((j_ff >= a_ff) && (j_ff <= b_ff)) begin
                  if ((m_ff != '0) && (sub_use == '0) && (last_use_ff == '0)) begin
                     wr_addr = IW'(m_ff - ONE_C);
                     wr_data = {q_end, UB'(0)};
                  end else begin
                     wr_addr     = m_ff[IW-1:0];
                     wr_data     = {q_end, sub_use};
                     m_in        = m_ff + ONE_C;
                     last_use_in = sub_use;
                  end
               end else begin
                  if ((m_ff != '0) && (q_use == '0) && (last_use_ff == '0)) begin
                     wr_addr = IW'(m_ff - ONE_C);
                     wr_data = {q_end, UB'(0)};
                  end else begin
                     wr_addr     = m_ff[IW-1:0];
                     wr_data     = rd_q_ff;
                     m_in        = m_ff + ONE_C;
                     last_use_in = q_use;
                  end
               end
               j_in    = j_next;
               rd_addr = j_next[IW-1:0];
            end
         end

         // Hand the response to the output register once it is free.
         cts_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = res_grant_ff;
               rsp_status_in = res_status_ff;
               state_in      = cts_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = cts_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted_start = rsp_grant_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef SYNTHESIS
   // The table never holds zero intervals nor more than its depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (n_ff != '0) && (n_ff <= CW'(MAX_INTERVALS)))
      else $error("interval count out of range");

   // A failed request never grants a start.
   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != cts_pkg::STATUS_OK)) |-> (rsp_granted_start == '0))
      else $error("granted start on a failed request");

   // In the cycle after a request is taken the block is not ready.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // A new response is loaded only from the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid)) |-> ($past(state_ff) == cts_pkg::ST_DONE))
      else $error("response loaded outside the done state");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for capacity_timeline_scheduler: random and directed requests
// are checked against an in-bench interval table predictor. Depends on cts_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

   localparam logic [31:0] T_INF = 32'hFFFF_FFFF;
   localparam int DEPTH = 64;
   localparam longint CYCLE_LIMIT = 40_000_000;

   typedef struct {
      bit        mode;
      bit [15:0] util;
      bit [31:0] st;
      bit [31:0] dur;
      bit [31:0] fin;
   } request_type;

   typedef struct {
      bit [31:0]           granted;
      cts_pkg::status_type status;
   } outcome_type;

   typedef struct {
      bit [15:0] util;
      bit [31:0] st;
      bit [31:0] fin;
   } task_entry_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic req_mode = 0;
   logic [15:0] req_util = 0;
   logic [31:0] req_start_time = 0;
   logic [31:0] req_duration = 0;
   logic [31:0] req_finish_time = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [31:0] rsp_granted_start;
   logic [1:0] rsp_status;
   logic csr_we = 0;
   logic [15:0] csr_wdata = 0;

   capacity_timeline_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_util(req_util), .req_start_time(req_start_time), .req_duration(req_duration),
      .req_finish_time(req_finish_time),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_granted_start(rsp_granted_start), .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // Shadow interval table.
   bit [31:0] tl_begin [DEPTH];
   bit [31:0] tl_end [DEPTH];
   bit [15:0] tl_usage [DEPTH];
   int        tl_count;
   bit [15:0] cap_value;

   request_type    pending_requests[$];
   outcome_type    expected_responses[$];
   task_entry_type running_tasks[$];
   int       error_count = 0;
   int       send_idle = 0;
   int       recv_stall = 0;
   longint   cycle_count = 0;

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Merges each run of idle intervals into one.
   function automatic void merge_idle_runs();
      bit [31:0] nb [DEPTH];
      bit [31:0] ne [DEPTH];
      bit [15:0] nu [DEPTH];
      int m;
      m = 0;
      for (int i = 0; i < DEPTH; i++) begin
         nb[i] = 0; ne[i] = 0; nu[i] = 0;
      end
      for (int i = 0; i < tl_count; i++) begin
         if (m > 0 && tl_usage[i] == 0 && nu[m-1] == 0) begin
            ne[m-1] = tl_end[i];
         end else if (m < DEPTH) begin
            nb[m] = tl_begin[i]; ne[m] = tl_end[i]; nu[m] = tl_usage[i];
            m++;
         end
      end
      tl_begin = nb; tl_end = ne; tl_usage = nu; tl_count = m;
   endfunction

   // Earliest-start search, then split and add usage.
   function automatic outcome_type schedule_task(request_type r);
      outcome_type o;
      bit [31:0] nb [DEPTH];
      bit [31:0] ne [DEPTH];
      bit [15:0] nu [DEPTH];
      bit [31:0] s, f, b, e;
      bit [16:0] peak;
      int i, k, m, extra;
      bit found;
      o.granted = 0;
      o.status = cts_pkg::STATUS_NO_FIT;
      found = 0;
      s = 0; f = 0; k = 0;
      for (i = 0; i < tl_count; i++) begin
         if (tl_end[i] <= r.st) continue;
         s = (r.st > tl_begin[i]) ? r.st : tl_begin[i];
         if (r.dur > T_INF - s) return o;
         f = s + r.dur;
         peak = 0;
         for (k = i; k < tl_count; k++) begin
            if (tl_usage[k] > peak) peak = {1'b0, tl_usage[k]};
            if (f <= tl_end[k]) break;
         end
         if (k >= tl_count) return o;
         if (peak + r.util <= {1'b0, cap_value}) begin
            found = 1;
            break;
         end
      end
      if (!found) return o;
      if (r.dur == 0) begin
         o.granted = s;
         o.status = cts_pkg::STATUS_OK;
         return o;
      end
      extra = (s > tl_begin[i] ? 1 : 0) + (f < tl_end[k] ? 1 : 0);
      if (tl_count + extra > DEPTH) begin
         o.status = cts_pkg::STATUS_FULL;
         return o;
      end
      for (int j = 0; j < DEPTH; j++) begin
         nb[j] = 0; ne[j] = 0; nu[j] = 0;
      end
      m = 0;
      for (int j = 0; j < i; j++) begin
         nb[m] = tl_begin[j]; ne[m] = tl_end[j]; nu[m] = tl_usage[j]; m++;
      end
      if (s > tl_begin[i]) begin
         nb[m] = tl_begin[i]; ne[m] = s; nu[m] = tl_usage[i]; m++;
      end
      for (int j = i; j <= k; j++) begin
         b = (tl_begin[j] > s) ? tl_begin[j] : s;
         e = (tl_end[j] < f) ? tl_end[j] : f;
         nb[m] = b; ne[m] = e; nu[m] = tl_usage[j] + r.util; m++;
      end
      if (f < tl_end[k]) begin
         nb[m] = f; ne[m] = tl_end[k]; nu[m] = tl_usage[k]; m++;
      end
      for (int j = k + 1; j < tl_count; j++) begin
         nb[m] = tl_begin[j]; ne[m] = tl_end[j]; nu[m] = tl_usage[j]; m++;
      end
      tl_begin = nb; tl_end = ne; tl_usage = nu; tl_count = m;
      o.granted = s;
      o.status = cts_pkg::STATUS_OK;
      return o;
   endfunction

   // Release usage between two exact interval edges.
   function automatic outcome_type complete_task(request_type r);
      outcome_type o;
      int a, b;
      bit fa, fb;
      o.granted = 0;
      o.status = cts_pkg::STATUS_OK;
      a = 0; b = 0; fa = 0; fb = 0;
      if (r.fin == r.st) return o;
      o.status = cts_pkg::STATUS_BOUNDS;
      if (r.fin < r.st) return o;
      for (int i = 0; i < tl_count; i++) begin
         if (!fa && tl_begin[i] == r.st) begin a = i; fa = 1; end
         if (!fb && tl_end[i] == r.fin) begin b = i; fb = 1; end
      end
      if (!fa || !fb || b < a) return o;
      for (int i = a; i <= b; i++)
         tl_usage[i] = (tl_usage[i] > r.util) ? tl_usage[i] - r.util : 16'd0;
      merge_idle_runs();
      o.status = cts_pkg::STATUS_OK;
      return o;
   endfunction

   // Driver: predicts each accepted request and presents the next one.
   always @(posedge clock) begin
      request_type cur, nxt;
      outcome_type o;
      task_entry_type t;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            cur.mode = req_mode; cur.util = req_util; cur.st = req_start_time;
            cur.dur = req_duration; cur.fin = req_finish_time;
            if (cur.mode == 0) begin
               o = schedule_task(cur);
               if (o.status == cts_pkg::STATUS_OK && cur.dur != 0) begin
                  t.util = cur.util;
                  t.st = o.granted;
                  t.fin = o.granted + cur.dur;
                  running_tasks.insert(running_tasks.size(), t);
               end
            end else begin
               o = complete_task(cur);
            end
            expected_responses.insert(expected_responses.size(), o);
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle) begin
               nxt = pending_requests.pop_front();
               req_valid <= 1;
               req_mode <= nxt.mode;
               req_util <= nxt.util;
               req_start_time <= nxt.st;
               req_duration <= nxt.dur;
               req_finish_time <= nxt.fin;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // Receiver stalls.
   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall);
   end

   // Monitor: compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      outcome_type o;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("response with nothing expected");
         end else begin
            o = expected_responses.pop_front();
            if (rsp_granted_start !== o.granted)
               report_mismatch($sformatf("granted_start %0h, expected %0h",
                                         rsp_granted_start, o.granted));
            if (rsp_status !== o.status)
               report_mismatch($sformatf("status %0d, expected %0d", rsp_status, o.status));
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Queues one request and waits until it has been taken.
   task automatic send_request(input bit mode, input bit [15:0] util, input bit [31:0] st,
                               input bit [31:0] dur, input bit [31:0] fin);
      request_type r;
      r.mode = mode;
      r.util = util;
      r.st = st;
      r.dur = dur;
      r.fin = fin;
      pending_requests.insert(pending_requests.size(), r);
      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
   endtask

   // Waits for the block to drain, then writes the capacity register.
   task automatic set_capacity(input bit [15:0] value);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= value;
      cap_value = value;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // Random request mix: mostly schedules and matching completes.
   task automatic random_request();
      int pick, idx;
      task_entry_type t;
      bit [15:0] u;
      bit [31:0] st, dur;
      pick = $urandom_range(99);
      u = ($urandom_range(99) < 4) ? 16'($urandom) : 16'($urandom_range(0, 3));
      if (pick < 50) begin
         st = ($urandom_range(99) < 4) ? $urandom : $urandom_range(0, 300);
         dur = ($urandom_range(99) < 4) ? $urandom : $urandom_range(0, 40);
         send_request(0, u, st, dur, $urandom);
      end else if (pick < 90 && running_tasks.size() > 0) begin
         idx = $urandom_range(running_tasks.size() - 1);
         t = running_tasks[idx];
         running_tasks.delete(idx);
         send_request(1, t.util, t.st, $urandom, t.fin);
      end else if ($urandom_range(1)) begin
         send_request(1, u, $urandom_range(0, 300), $urandom, $urandom_range(0, 340));
      end else begin
         send_request(1, 16'($urandom), $urandom, $urandom, $urandom);
      end
   endtask

   // Stimulus and end of run.
   initial begin
      bit [15:0] caps [5];
      cap_value = 1;
      tl_count = 1;
      for (int i = 0; i < DEPTH; i++) begin
         tl_begin[i] = 0; tl_end[i] = 0; tl_usage[i] = 0;
      end
      tl_end[0] = T_INF;
      repeat (12) @(posedge clock);
      reset <= 0;

      // Directed requests at reset capacity.
      send_request(0, 0, 0, 0, 0);
      send_request(0, 1, 0, 10, 0);
      send_request(0, 16'hFFFF, 0, 5, 0);
      send_request(0, 1, T_INF, 1, 0);
      send_request(0, 1, 32'hFFFF_FFFE, 5, 0);
      send_request(0, 0, 0, 32'hFFFF_FFFE, 0);
      send_request(0, 1, 20, 32'hFFFF_FFF0, 0);
      send_request(1, 1, 7, 0, 7);
      send_request(1, 1, 9, 0, 4);
      send_request(1, 1, 3, 0, 7);
      send_request(1, 16'hFFFF, 0, 0, 10);
      send_request(1, 16'hFFFF, 0, 0, T_INF);
      send_request(0, 1, 5, 3, 0);
      send_request(1, 1, 5, 0, 8);

      caps = '{16'd1, 16'hFFFF, 16'd3, 16'd0, 16'hFFFF};
      caps[3] = 16'($urandom_range(2, 10));
      for (int ph = 0; ph < 5; ph++) begin
         send_idle  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 48 : 26) : 0;
         recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 48 : 26) : 0;
         // Clear the whole timeline so each phase starts empty.
         send_request(1, 16'hFFFF, 0, 0, T_INF);
         running_tasks.delete();
         set_capacity(caps[ph]);
         // Many short disjoint tasks fill the table.
         if (caps[ph] == 16'hFFFF && ph == 1) begin
            for (int j = 0; j < 34; j++) send_request(0, 1, 2 * j + 1, 1, 0);
         end
         for (int n = 0; n < 400; n++) random_request();
      end

      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
